// ===== design/acfp_pkg.sv =====
`default_nettype none

package acfp_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned PERIPH_W = 3;
	localparam int unsigned ACTION_W = 2;
	localparam int unsigned GROUP_W  = 2;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned OUT_DATA_W = 8;

	localparam logic [BYTE_W-1:0] START_CHAR_RST = 8'h3A;
	localparam logic [BYTE_W-1:0] END_CHAR_RST   = 8'h0A;

	localparam logic [CFG_IDX_W-1:0] REG_START_CHAR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_END_CHAR   = 1'b1;

	localparam logic [BYTE_W-1:0] CH_0 = 8'h30;
	localparam logic [BYTE_W-1:0] CH_1 = 8'h31;
	localparam logic [BYTE_W-1:0] CH_2 = 8'h32;
	localparam logic [BYTE_W-1:0] CH_3 = 8'h33;
	localparam logic [BYTE_W-1:0] CH_E = 8'h45;
	localparam logic [BYTE_W-1:0] CH_A = 8'h41;
	localparam logic [BYTE_W-1:0] CH_T = 8'h54;
	localparam logic [BYTE_W-1:0] CH_R = 8'h52;

	localparam logic [GROUP_W-1:0] GRP_LED    = 2'd0;
	localparam logic [GROUP_W-1:0] GRP_SWITCH = 2'd1;
	localparam logic [GROUP_W-1:0] GRP_ACCEL  = 2'd2;
	localparam logic [GROUP_W-1:0] GRP_LIGHT  = 2'd3;

	localparam logic [PERIPH_W-1:0] PER_RED_LED   = 3'd0;
	localparam logic [PERIPH_W-1:0] PER_GREEN_LED = 3'd1;
	localparam logic [PERIPH_W-1:0] PER_SWITCH1   = 3'd2;
	localparam logic [PERIPH_W-1:0] PER_SWITCH3   = 3'd3;
	localparam logic [PERIPH_W-1:0] PER_ACCEL     = 3'd4;
	localparam logic [PERIPH_W-1:0] PER_LIGHT     = 3'd5;

	localparam logic [ACTION_W-1:0] ACT_ON     = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_OFF    = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TOGGLE = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_READ   = 2'd3;

endpackage

`default_nettype wire

// ===== design/ascii_command_frame_parser.sv =====
`default_nettype none

// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/tready         tdata[7:0] rx_byte
// m_axis    out  m_axis_tvalid/tready         tdata[2:0] peripheral, [4:3] action
// cfg       in   cfg_we (no back-pressure)    cfg_index, cfg_wdata
//
// One word per clock while the result side takes results; each byte is held in
// the input register, then the parser updates and the result register loads.
// The input register stalls only when the result register is full and not taken.
// arst_n clears the parser to waiting for the start char and restores default chars.

module ascii_command_frame_parser
	import acfp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output      logic                  s_axis_tready,
	input  wire logic [BYTE_W-1:0]     s_axis_tdata,  // [7:0] rx_byte
	output      logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output      logic [OUT_DATA_W-1:0] m_axis_tdata,  // [2:0] peripheral, [4:3] action
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [BYTE_W-1:0]     cfg_wdata
);

	typedef enum logic [2:0] {
		ST_WAIT_START = 3'd0,
		ST_PREFIX     = 3'd1,
		ST_GROUP      = 3'd2,
		ST_INDEX      = 3'd3,
		ST_ACTION     = 3'd4,
		ST_WAIT_END   = 3'd5
	} state_t;

	logic [BYTE_W-1:0]   start_char_q, end_char_q;
	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	state_t              state_q, state_d;
	logic                expect_q, expect_d;
	logic [GROUP_W-1:0]  group_q, group_d;
	logic [PERIPH_W-1:0] periph_q, periph_d;
	logic [ACTION_W-1:0] action_q, action_d;
	logic                emit;
	logic                out_valid_q;
	logic [PERIPH_W-1:0] out_periph_q;
	logic [ACTION_W-1:0] out_action_q;
	logic                out_free, fire_s1;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign fire_s1       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-PERIPH_W-ACTION_W){1'b0}}, out_action_q, out_periph_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_char_q <= START_CHAR_RST;
			end_char_q   <= END_CHAR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_CHAR: start_char_q <= cfg_wdata;
				REG_END_CHAR:   end_char_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
			byte_s1  <= s_axis_tdata;
		end
	end

	always_comb begin
		state_d  = state_q;
		expect_d = expect_q;
		group_d  = group_q;
		periph_d = periph_q;
		action_d = action_q;
		emit     = 1'b0;
		if (byte_s1 == start_char_q) begin
			state_d  = ST_PREFIX;
			expect_d = 1'b1;
		end else begin
			unique case (state_q)
				ST_PREFIX: begin
					if (expect_q) begin
						if (byte_s1 == CH_1) expect_d = 1'b0;
						else state_d = ST_WAIT_START;
					end else if (byte_s1 == CH_0) begin
						state_d = ST_GROUP;
					end else begin
						state_d = ST_WAIT_START;
					end
				end
				ST_GROUP: begin
					if (byte_s1[BYTE_W-1:GROUP_W] == CH_0[BYTE_W-1:GROUP_W]) begin
						group_d = byte_s1[GROUP_W-1:0];
						state_d = ST_INDEX;
					end else begin
						state_d = ST_WAIT_START;
					end
				end
				ST_INDEX: begin
					state_d = ST_WAIT_START;
					case (group_q)
						GRP_LED: begin
							if (byte_s1 == CH_1) begin
								periph_d = PER_RED_LED;
								state_d  = ST_ACTION;
							end else if (byte_s1 == CH_2) begin
								periph_d = PER_GREEN_LED;
								state_d  = ST_ACTION;
							end
						end
						GRP_SWITCH: begin
							if (byte_s1 == CH_1 || byte_s1 == CH_3) begin
								periph_d = (byte_s1 == CH_1) ? PER_SWITCH1 : PER_SWITCH3;
								action_d = ACT_READ;
								state_d  = ST_WAIT_END;
							end
						end
						default: begin
							if (byte_s1 == CH_0) begin
								periph_d = (group_q == GRP_ACCEL) ? PER_ACCEL : PER_LIGHT;
								action_d = ACT_READ;
								state_d  = ST_WAIT_END;
							end
						end
					endcase
				end
				ST_ACTION: begin
					state_d = ST_WAIT_END;
					case (byte_s1)
						CH_E:    action_d = ACT_ON;
						CH_A:    action_d = ACT_OFF;
						CH_T:    action_d = ACT_TOGGLE;
						CH_R:    action_d = ACT_READ;
						default: state_d  = ST_WAIT_START;
					endcase
				end
				ST_WAIT_END: begin
					emit    = (byte_s1 == end_char_q);
					state_d = ST_WAIT_START;
				end
				default: state_d = ST_WAIT_START;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_WAIT_START;
			expect_q     <= 1'b0;
			group_q      <= '0;
			periph_q     <= '0;
			action_q     <= '0;
			out_valid_q  <= 1'b0;
			out_periph_q <= '0;
			out_action_q <= '0;
		end else begin
			if (fire_s1) begin
				state_q  <= state_d;
				expect_q <= expect_d;
				group_q  <= group_d;
				periph_q <= periph_d;
				action_q <= action_d;
			end
			if (fire_s1 && emit) begin
				out_valid_q  <= 1'b1;
				out_periph_q <= periph_q;
				out_action_q <= action_q;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_result_from_wait_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_WAIT_END))
		else $error("result raised outside wait-end state");

	a_stalled_word_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(byte_s1)))
		else $error("stalled input word lost");

	a_back_to_wait_start: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && state_q == ST_WAIT_END && byte_s1 != start_char_q)
		|=> state_q == ST_WAIT_START)
		else $error("parser did not return to wait-start after frame end");

	a_result_periph_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_periph_q <= PER_LIGHT))
		else $error("peripheral code out of range");

endmodule

`default_nettype wire

// ===== sim/tb_ascii_command_frame_parser.sv =====
`timescale 1ns / 1ps

module tb_ascii_command_frame_parser;
	import acfp_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 150;
	localparam int SETTLE      = 4;

	typedef enum logic [2:0] {
		PS_WAIT_START,
		PS_PREFIX,
		PS_GROUP,
		PS_ID,
		PS_ACTION,
		PS_WAIT_END
	} parse_e;

	typedef struct packed {
		logic [PERIPH_W-1:0] periph;
		logic [ACTION_W-1:0] act;
	} cmd_t;

	class cmd_tracker;
		logic [BYTE_W-1:0]  start_ch;
		logic [BYTE_W-1:0]  end_ch;
		parse_e             state;
		logic               want_one;
		logic [GROUP_W-1:0] grp;
		cmd_t               held;
		cmd_t               due_q[$];
		int                 errors;
		int                 n_bytes;
		int                 n_cmds;

		function new();
			start_ch = START_CHAR_RST;
			end_ch   = END_CHAR_RST;
			state    = PS_WAIT_START;
			want_one = 1'b0;
			grp      = '0;
			held     = '0;
			errors   = 0;
			n_bytes  = 0;
			n_cmds   = 0;
		endfunction

		function void set_char(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] v);
			if (idx == REG_START_CHAR) begin
				start_ch = v;
			end else if (idx == REG_END_CHAR) begin
				end_ch = v;
			end
		endfunction

		// advance the parser by one byte, queue a command when a frame closes
		function void note_byte(logic [BYTE_W-1:0] b);
			logic                hit;
			logic [PERIPH_W-1:0] p;
			n_bytes++;
			if (b == start_ch) begin
				state    = PS_PREFIX;
				want_one = 1'b1;
				return;
			end
			hit = 1'b1;
			p   = '0;
			case (state)
			PS_PREFIX: begin
				if (want_one) begin
					if (b == CH_1) want_one = 1'b0;
					else state = PS_WAIT_START;
				end else begin
					state = (b == CH_0) ? PS_GROUP : PS_WAIT_START;
				end
			end
			PS_GROUP: begin
				if (b >= CH_0 && b <= CH_3) begin
					grp   = GROUP_W'(b - CH_0);
					state = PS_ID;
				end else begin
					state = PS_WAIT_START;
				end
			end
			PS_ID: begin
				case (grp)
				GRP_LED: begin
					if (b == CH_1) p = PER_RED_LED;
					else if (b == CH_2) p = PER_GREEN_LED;
					else hit = 1'b0;
				end
				GRP_SWITCH: begin
					if (b == CH_1) p = PER_SWITCH1;
					else if (b == CH_3) p = PER_SWITCH3;
					else hit = 1'b0;
				end
				GRP_ACCEL: begin
					if (b == CH_0) p = PER_ACCEL;
					else hit = 1'b0;
				end
				default: begin
					if (b == CH_0) p = PER_LIGHT;
					else hit = 1'b0;
				end
				endcase
				if (!hit) begin
					state = PS_WAIT_START;
				end else begin
					held.periph = p;
					if (p == PER_RED_LED || p == PER_GREEN_LED) begin
						state = PS_ACTION;
					end else begin
						held.act = ACT_READ;
						state    = PS_WAIT_END;
					end
				end
			end
			PS_ACTION: begin
				state = PS_WAIT_END;
				case (b)
				CH_E: held.act = ACT_ON;
				CH_A: held.act = ACT_OFF;
				CH_T: held.act = ACT_TOGGLE;
				CH_R: held.act = ACT_READ;
				default: state = PS_WAIT_START;
				endcase
			end
			PS_WAIT_END: begin
				if (b == end_ch) due_q.push_back(held);
				state = PS_WAIT_START;
			end
			default: state = PS_WAIT_START;
			endcase
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_command(logic [OUT_DATA_W-1:0] d);
			cmd_t want;
			if (due_q.size() == 0) begin
				report($sformatf("command word %h with none expected", d));
				return;
			end
			want = due_q.pop_front();
			n_cmds++;
			if (d[PERIPH_W-1:0] !== want.periph)
				report($sformatf("peripheral %0d, expected %0d", d[PERIPH_W-1:0], want.periph));
			if (d[PERIPH_W+ACTION_W-1:PERIPH_W] !== want.act)
				report($sformatf("action %0d, expected %0d",
					d[PERIPH_W+ACTION_W-1:PERIPH_W], want.act));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [BYTE_W-1:0]     s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [BYTE_W-1:0]     cfg_wdata = '0;

	cmd_tracker        sb;
	logic [BYTE_W-1:0] frame_bytes[$];
	logic [BYTE_W-1:0] cur_start = START_CHAR_RST;
	logic [BYTE_W-1:0] cur_end = END_CHAR_RST;
	bit                steady = 1'b0;
	bit                hold_req = 1'b0;
	int                hold_left = 0;
	int                sent = 0;
	int                n_settings = 1;
	int                stuck = 0;

	ascii_command_frame_parser u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side back-pressure
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= steady || ($urandom_range(99) >= 27);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) sb.check_command(m_axis_tdata);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stuck = 0;
		else
			stuck++;
		if (stuck == STALL_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_byte(logic [BYTE_W-1:0] b);
		int gap;
		gap = 0;
		while (!steady && $urandom_range(99) < 27) gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	task automatic send_frame_bytes();
		while (frame_bytes.size() != 0) send_byte(frame_bytes.pop_front());
	endtask

	// wait for every queued command, then let in-flight bytes settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.due_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_chars(logic [BYTE_W-1:0] s, logic [BYTE_W-1:0] e);
		cfg_we    <= 1'b1;
		cfg_index <= REG_START_CHAR;
		cfg_wdata <= s;
		@(posedge clk);
		cfg_index <= REG_END_CHAR;
		cfg_wdata <= e;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_char(REG_START_CHAR, s);
		sb.set_char(REG_END_CHAR, e);
		cur_start = s;
		cur_end   = e;
		n_settings++;
	endtask

	function automatic void load_frame(int unsigned per, int unsigned act);
		logic [BYTE_W-1:0] g;
		logic [BYTE_W-1:0] id;
		logic [BYTE_W-1:0] letter;
		case (per[PERIPH_W-1:0])
		PER_RED_LED:   begin g = CH_0; id = CH_1; end
		PER_GREEN_LED: begin g = CH_0; id = CH_2; end
		PER_SWITCH1:   begin g = CH_1; id = CH_1; end
		PER_SWITCH3:   begin g = CH_1; id = CH_3; end
		PER_ACCEL:     begin g = CH_2; id = CH_0; end
		default:       begin g = CH_3; id = CH_0; end
		endcase
		case (act[ACTION_W-1:0])
		ACT_ON:     letter = CH_E;
		ACT_OFF:    letter = CH_A;
		ACT_TOGGLE: letter = CH_T;
		default:    letter = CH_R;
		endcase
		frame_bytes = '{cur_start, CH_1, CH_0, g, id};
		if (g == CH_0) frame_bytes.push_back(letter);
		frame_bytes.push_back(cur_end);
	endfunction

	// mostly good frames with random content, the rest corrupted, cut short,
	// restarted part way or plain line noise
	task automatic random_traffic(int budget);
		int                stop;
		int                kind;
		int                cut;
		int                pos;
		logic [BYTE_W-1:0] head[$];
		stop = sent + budget;
		while (sent < stop) begin
			kind = $urandom_range(99);
			load_frame($urandom_range(5), $urandom_range(3));
			if (kind < 62) begin
			end else if (kind < 74) begin
				pos = $urandom_range(1, frame_bytes.size() - 1);
				frame_bytes[pos] = $urandom_range(1) ? BYTE_W'($urandom_range(CH_0, CH_3))
				                                     : BYTE_W'($urandom_range(255));
			end else if (kind < 82) begin
				cut = $urandom_range(1, frame_bytes.size() - 1);
				repeat (cut) frame_bytes.delete(frame_bytes.size() - 1);
			end else if (kind < 90) begin
				head = frame_bytes;
				cut  = $urandom_range(1, 4);
				for (int i = cut - 1; i >= 0; i--) frame_bytes.push_front(head[i]);
			end else begin
				frame_bytes.delete();
				repeat ($urandom_range(1, 6)) frame_bytes.push_back(BYTE_W'($urandom_range(255)));
			end
			send_frame_bytes();
		end
	endtask

	initial begin
		logic [BYTE_W-1:0] directed[$];
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, restart mid-frame, bad end byte, bad action letter
		directed = '{8'h00, 8'hFF,
			START_CHAR_RST, CH_1, CH_0, CH_0, CH_1, CH_E, END_CHAR_RST,
			START_CHAR_RST, CH_1, START_CHAR_RST, CH_1, CH_0, CH_1, CH_3, END_CHAR_RST,
			START_CHAR_RST, CH_1, CH_0, CH_3, CH_0, CH_A,
			START_CHAR_RST, CH_1, CH_0, CH_0, CH_2, 8'h51};
		foreach (directed[i]) send_byte(directed[i]);
		drain();

		random_traffic(110);
		hold_req = 1'b1;
		random_traffic(60);
		drain();
		random_traffic(80);
		drain();

		set_chars(8'h00, 8'hFF);
		steady = 1'b1;
		random_traffic(100);
		steady = 1'b0;
		drain();

		set_chars(8'hFF, 8'h00);
		random_traffic(100);
		drain();

		// same byte for start and end: nothing can complete
		set_chars(8'h23, 8'h23);
		random_traffic(40);
		drain();

		set_chars(CH_1, 8'h0D);
		random_traffic(50);
		drain();

		set_chars(START_CHAR_RST, END_CHAR_RST);
		random_traffic(80);
		drain();

		if (sb.due_q.size() != 0)
			sb.report($sformatf("%0d commands never came out", sb.due_q.size()));
		$display("covered %0d bytes, %0d decoded commands checked, %0d start/end settings",
			sb.n_bytes, sb.n_cmds, n_settings);
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
